FILE: hw/rtl/vau_pkg.sv
// ----------------------------------------------------------------------------
// vau_pkg
// Shared types, widths and helper functions of the vector arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vau_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int SAT_IN_W   = SUM_W + 1;
    localparam int SQRT_STEPS = DATA_W;
    localparam int ROOT_W     = DATA_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int MAG_W      = ROOT_W + 1;
    localparam int DIV_W      = DATA_W + FRAC_BITS;
    localparam int DREM_W     = MAG_W;
    localparam int NUM_COMP   = 3;

    typedef enum logic [2:0] {
        OP_NEG   = 3'd0,
        OP_SUB   = 3'd1,
        OP_ADD   = 3'd2,
        OP_DOT   = 3'd3,
        OP_CROSS = 3'd4,
        OP_SCALE = 3'd5,
        OP_MAG   = 3'd6,
        OP_UNIT  = 3'd7
    } op_t;

    typedef struct packed {
        logic                     flag;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    // Per-transaction data that travels alongside the root and divider stages
    typedef struct packed {
        op_t                      kind;
        logic signed [DATA_W-1:0] r_x;
        logic signed [DATA_W-1:0] r_y;
        logic signed [DATA_W-1:0] r_z;
        logic signed [DATA_W-1:0] scalar;
        logic                     sat;
        logic signed [DATA_W-1:0] a_x;
        logic signed [DATA_W-1:0] a_y;
        logic signed [DATA_W-1:0] a_z;
    } side_t;

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX =
        {{(SAT_IN_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN =
        {{(SAT_IN_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic [SAT_IN_W-1:0] HALF_Q = SAT_IN_W'(1) << (FRAC_BITS - 1);

    function automatic sat_t sat32(input logic signed [SAT_IN_W-1:0] v);
        sat_t r;
        if (v > SAT_MAX) begin
            r.flag = 1'b1;
            r.val  = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r.flag = 1'b1;
            r.val  = SAT_MIN[DATA_W-1:0];
        end else begin
            r.flag = 1'b0;
            r.val  = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAT_IN_W-1:0] ext32(input logic signed [DATA_W-1:0] v);
        return {{(SAT_IN_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    // round to nearest, ties up, then saturate
    function automatic sat_t rnd_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SAT_IN_W-1:0] t;
        t = $signed({v[SUM_W-1], v}) + $signed(HALF_Q);
        t = t >>> FRAC_BITS;
        return sat32(t);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vau_front.sv
// ----------------------------------------------------------------------------
// vau_front
// Operand select, six multipliers, sums and rounding (four stages).
// ----------------------------------------------------------------------------
`default_nettype none

module vau_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire vau_pkg::op_t                     in_kind,
    input  wire logic signed [vau_pkg::DATA_W-1:0] in_a_x,
    input  wire logic signed [vau_pkg::DATA_W-1:0] in_a_y,
    input  wire logic signed [vau_pkg::DATA_W-1:0] in_a_z,
    input  wire logic signed [vau_pkg::DATA_W-1:0] in_b_x,
    input  wire logic signed [vau_pkg::DATA_W-1:0] in_b_y,
    input  wire logic signed [vau_pkg::DATA_W-1:0] in_b_z,
    input  wire logic signed [vau_pkg::DATA_W-1:0] in_f,
    output logic                                  out_valid,
    output vau_pkg::side_t                        out_side,
    output logic [vau_pkg::PROD_W-1:0]            out_sumsq
);

    logic signed [vau_pkg::DATA_W-1:0] a_in [vau_pkg::NUM_COMP];
    logic signed [vau_pkg::DATA_W-1:0] b_in [vau_pkg::NUM_COMP];

    // stage A
    logic                              vld_a_reg;
    vau_pkg::op_t                      kind_a_reg;
    logic signed [vau_pkg::DATA_W-1:0] a_a_reg   [vau_pkg::NUM_COMP];
    logic signed [vau_pkg::DATA_W-1:0] op1_reg   [2*vau_pkg::NUM_COMP];
    logic signed [vau_pkg::DATA_W-1:0] op2_reg   [2*vau_pkg::NUM_COMP];
    logic signed [vau_pkg::DATA_W-1:0] op1_next  [2*vau_pkg::NUM_COMP];
    logic signed [vau_pkg::DATA_W-1:0] op2_next  [2*vau_pkg::NUM_COMP];
    logic signed [vau_pkg::DATA_W-1:0] lin_a_reg [vau_pkg::NUM_COMP];
    logic signed [vau_pkg::DATA_W-1:0] lin_next  [vau_pkg::NUM_COMP];
    logic                              lsat_a_reg;
    logic                              lsat_next;

    // stage B
    logic                              vld_b_reg;
    vau_pkg::op_t                      kind_b_reg;
    logic signed [vau_pkg::DATA_W-1:0] a_b_reg   [vau_pkg::NUM_COMP];
    logic signed [vau_pkg::PROD_W-1:0] prod_reg  [2*vau_pkg::NUM_COMP];
    logic signed [vau_pkg::DATA_W-1:0] lin_b_reg [vau_pkg::NUM_COMP];
    logic                              lsat_b_reg;

    // stage C
    logic                              vld_c_reg;
    vau_pkg::op_t                      kind_c_reg;
    logic signed [vau_pkg::DATA_W-1:0] a_c_reg   [vau_pkg::NUM_COMP];
    logic signed [vau_pkg::SUM_W-1:0]  dif_reg   [vau_pkg::NUM_COMP];
    logic signed [vau_pkg::SUM_W-1:0]  sum_reg;
    logic signed [vau_pkg::DATA_W-1:0] lin_c_reg [vau_pkg::NUM_COMP];
    logic                              lsat_c_reg;

    // stage D
    logic                              vld_d_reg;
    vau_pkg::side_t                    side_d_reg;
    vau_pkg::side_t                    side_d_next;
    logic [vau_pkg::PROD_W-1:0]        sumsq_d_reg;

    assign a_in[0] = in_a_x;
    assign a_in[1] = in_a_y;
    assign a_in[2] = in_a_z;
    assign b_in[0] = in_b_x;
    assign b_in[1] = in_b_y;
    assign b_in[2] = in_b_z;

    always_comb begin
        vau_pkg::sat_t                     sr;
        logic signed [vau_pkg::SAT_IN_W-1:0] w;
        for (int i = 0; i < vau_pkg::NUM_COMP; i++) begin
            op1_next[i]                     = a_in[i];
            op2_next[i]                     = a_in[i];
            op1_next[i+vau_pkg::NUM_COMP]   = '0;
            op2_next[i+vau_pkg::NUM_COMP]   = '0;
        end
        case (in_kind)
            vau_pkg::OP_DOT: begin
                for (int i = 0; i < vau_pkg::NUM_COMP; i++) begin
                    op2_next[i] = b_in[i];
                end
            end
            vau_pkg::OP_CROSS: begin
                op1_next[0] = a_in[1]; op2_next[0] = b_in[2];
                op1_next[3] = b_in[1]; op2_next[3] = a_in[2];
                op1_next[1] = a_in[2]; op2_next[1] = b_in[0];
                op1_next[4] = b_in[2]; op2_next[4] = a_in[0];
                op1_next[2] = a_in[0]; op2_next[2] = b_in[1];
                op1_next[5] = b_in[0]; op2_next[5] = a_in[1];
            end
            vau_pkg::OP_SCALE: begin
                for (int i = 0; i < vau_pkg::NUM_COMP; i++) begin
                    op2_next[i] = in_f;
                end
            end
            default: begin
            end
        endcase
        lsat_next = 1'b0;
        for (int i = 0; i < vau_pkg::NUM_COMP; i++) begin
            case (in_kind)
                vau_pkg::OP_NEG: w = -vau_pkg::ext32(a_in[i]);
                vau_pkg::OP_SUB: w = vau_pkg::ext32(a_in[i]) - vau_pkg::ext32(b_in[i]);
                default:         w = vau_pkg::ext32(a_in[i]) + vau_pkg::ext32(b_in[i]);
            endcase
            sr          = vau_pkg::sat32(w);
            lin_next[i] = sr.val;
            lsat_next   = lsat_next | sr.flag;
        end
    end

    always_comb begin
        vau_pkg::sat_t rd [vau_pkg::NUM_COMP];
        vau_pkg::sat_t rs;
        for (int i = 0; i < vau_pkg::NUM_COMP; i++) begin
            rd[i] = vau_pkg::rnd_sat(dif_reg[i]);
        end
        rs               = vau_pkg::rnd_sat(sum_reg);
        side_d_next.kind = kind_c_reg;
        side_d_next.a_x  = a_c_reg[0];
        side_d_next.a_y  = a_c_reg[1];
        side_d_next.a_z  = a_c_reg[2];
        side_d_next.r_x  = '0;
        side_d_next.r_y  = '0;
        side_d_next.r_z  = '0;
        side_d_next.scalar = '0;
        side_d_next.sat  = 1'b0;
        case (kind_c_reg)
            vau_pkg::OP_NEG, vau_pkg::OP_SUB, vau_pkg::OP_ADD: begin
                side_d_next.r_x = lin_c_reg[0];
                side_d_next.r_y = lin_c_reg[1];
                side_d_next.r_z = lin_c_reg[2];
                side_d_next.sat = lsat_c_reg;
            end
            vau_pkg::OP_DOT: begin
                side_d_next.scalar = rs.val;
                side_d_next.sat    = rs.flag;
            end
            vau_pkg::OP_CROSS, vau_pkg::OP_SCALE: begin
                side_d_next.r_x = rd[0].val;
                side_d_next.r_y = rd[1].val;
                side_d_next.r_z = rd[2].val;
                side_d_next.sat = rd[0].flag | rd[1].flag | rd[2].flag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind_a_reg <= in_kind;
            lsat_a_reg <= lsat_next;
            kind_b_reg <= kind_a_reg;
            lsat_b_reg <= lsat_a_reg;
            kind_c_reg <= kind_b_reg;
            lsat_c_reg <= lsat_b_reg;
            for (int i = 0; i < 2*vau_pkg::NUM_COMP; i++) begin
                op1_reg[i]  <= op1_next[i];
                op2_reg[i]  <= op2_next[i];
                prod_reg[i] <= op1_reg[i] * op2_reg[i];
            end
            for (int i = 0; i < vau_pkg::NUM_COMP; i++) begin
                a_a_reg[i]   <= a_in[i];
                lin_a_reg[i] <= lin_next[i];
                a_b_reg[i]   <= a_a_reg[i];
                lin_b_reg[i] <= lin_a_reg[i];
                a_c_reg[i]   <= a_b_reg[i];
                lin_c_reg[i] <= lin_b_reg[i];
                dif_reg[i]   <= {{2{prod_reg[i][vau_pkg::PROD_W-1]}}, prod_reg[i]}
                    - {{2{prod_reg[i+3][vau_pkg::PROD_W-1]}}, prod_reg[i+3]};
            end
            sum_reg <= {{2{prod_reg[0][vau_pkg::PROD_W-1]}}, prod_reg[0]}
                + {{2{prod_reg[1][vau_pkg::PROD_W-1]}}, prod_reg[1]}
                + {{2{prod_reg[2][vau_pkg::PROD_W-1]}}, prod_reg[2]};
            side_d_reg  <= side_d_next;
            sumsq_d_reg <= sum_reg[vau_pkg::PROD_W-1:0];
        end
    end

    assign out_valid = vld_d_reg;
    assign out_side  = side_d_reg;
    assign out_sumsq = sumsq_d_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/vau_sqrt.sv
// ----------------------------------------------------------------------------
// vau_sqrt
// Pipelined integer square root, one result bit per stage, rounded at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_sqrt (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire vau_pkg::side_t               in_side,
    input  wire logic [vau_pkg::PROD_W-1:0]   in_s,
    output logic                              out_valid,
    output vau_pkg::side_t                    out_side,
    output logic [vau_pkg::MAG_W-1:0]         out_mag
);

    localparam int N = vau_pkg::SQRT_STEPS;

    logic [N-1:0]                     vld_reg;
    logic [vau_pkg::PROD_W-1:0]       s_reg    [N];
    logic [vau_pkg::ROOT_W-1:0]       root_reg [N];
    logic [vau_pkg::REM_W-1:0]        rem_reg  [N];
    vau_pkg::side_t                   side_reg [N];

    logic                             vld_r_reg;
    vau_pkg::side_t                   side_r_reg;
    logic [vau_pkg::MAG_W-1:0]        mag_r_reg;

    for (genvar g = 0; g < N; g++) begin : g_step
        logic                         v_in;
        logic [vau_pkg::PROD_W-1:0]   s_in;
        logic [vau_pkg::ROOT_W-1:0]   root_in;
        logic [vau_pkg::REM_W-1:0]    rem_in;
        vau_pkg::side_t               side_in;
        logic [vau_pkg::REM_W+1:0]    sh;
        logic [vau_pkg::REM_W+1:0]    trial;
        logic [vau_pkg::ROOT_W-1:0]   root_next;
        logic [vau_pkg::REM_W-1:0]    rem_next;

        if (g == 0) begin : g_first
            assign v_in    = in_valid;
            assign s_in    = in_s;
            assign root_in = '0;
            assign rem_in  = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = vld_reg[g-1];
            assign s_in    = s_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        always_comb begin
            sh    = {rem_in, s_in[vau_pkg::PROD_W-1-2*g -: 2]};
            trial = {2'b00, root_in, 2'b01};
            if (sh >= trial) begin
                rem_next  = vau_pkg::REM_W'(sh - trial);
                root_next = {root_in[vau_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = sh[vau_pkg::REM_W-1:0];
                root_next = {root_in[vau_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[g]    <= s_in;
                root_reg[g] <= root_next;
                rem_reg[g]  <= rem_next;
                side_reg[g] <= side_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_r_reg <= 1'b0;
        end else if (en) begin
            vld_r_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_r_reg <= side_reg[N-1];
            mag_r_reg  <= {1'b0, root_reg[N-1]}
                + vau_pkg::MAG_W'(rem_reg[N-1] > {2'b00, root_reg[N-1]});
        end
    end

    assign out_valid = vld_r_reg;
    assign out_side  = side_r_reg;
    assign out_mag   = mag_r_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/vau_div.sv
// ----------------------------------------------------------------------------
// vau_div
// Three-lane pipelined restoring divider for the unit vector, and the
// final result register with magnitude and zero-length handling.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire vau_pkg::side_t                    in_side,
    input  wire logic [vau_pkg::MAG_W-1:0]         in_mag,
    output logic                                   out_valid,
    output logic signed [vau_pkg::DATA_W-1:0]      out_r_x,
    output logic signed [vau_pkg::DATA_W-1:0]      out_r_y,
    output logic signed [vau_pkg::DATA_W-1:0]      out_r_z,
    output logic signed [vau_pkg::DATA_W-1:0]      out_scalar,
    output logic                                   out_sat,
    output logic                                   out_zl
);

    localparam int N = vau_pkg::DIV_W;
    localparam int L = vau_pkg::NUM_COMP;

    // prep stage
    logic                              vld_p_reg;
    vau_pkg::side_t                    side_p_reg;
    logic [vau_pkg::MAG_W-1:0]         mag_p_reg;
    logic [N-1:0]                      n_p_reg   [L];
    logic [L-1:0]                      neg_p_reg;
    logic [N-1:0]                      n_p_next  [L];
    logic signed [vau_pkg::DATA_W-1:0] a_sel     [L];

    // divider stages
    logic [N-1:0]                      vld_reg;
    vau_pkg::side_t                    side_reg  [N];
    logic [vau_pkg::MAG_W-1:0]         mag_reg   [N];
    logic [L-1:0]                      neg_reg   [N];
    logic [N-1:0]                      n_reg     [N][L];
    logic [N-1:0]                      q_reg     [N][L];
    logic [vau_pkg::DREM_W-1:0]        rem_reg   [N][L];

    // result register
    logic                              vld_o_reg;
    logic signed [vau_pkg::DATA_W-1:0] r_o_reg   [L];
    logic signed [vau_pkg::DATA_W-1:0] r_o_next  [L];
    logic signed [vau_pkg::DATA_W-1:0] sc_o_reg;
    logic signed [vau_pkg::DATA_W-1:0] sc_o_next;
    logic                              sat_o_reg;
    logic                              sat_o_next;
    logic                              zl_o_reg;
    logic                              zl_o_next;

    assign a_sel[0] = in_side.a_x;
    assign a_sel[1] = in_side.a_y;
    assign a_sel[2] = in_side.a_z;

    always_comb begin
        logic [vau_pkg::DATA_W-1:0] mag_a;
        for (int l = 0; l < L; l++) begin
            mag_a       = a_sel[l][vau_pkg::DATA_W-1] ? vau_pkg::DATA_W'(-a_sel[l])
                                                      : a_sel[l];
            n_p_next[l] = {mag_a, {vau_pkg::FRAC_BITS{1'b0}}}
                + {{(N-vau_pkg::MAG_W+1){1'b0}}, in_mag[vau_pkg::MAG_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_p_reg <= 1'b0;
        end else if (en) begin
            vld_p_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_p_reg <= in_side;
            mag_p_reg  <= in_mag;
            for (int l = 0; l < L; l++) begin
                n_p_reg[l]   <= n_p_next[l];
                neg_p_reg[l] <= a_sel[l][vau_pkg::DATA_W-1];
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        logic                        v_in;
        vau_pkg::side_t              side_in;
        logic [vau_pkg::MAG_W-1:0]   mag_in;
        logic [L-1:0]                neg_in;
        logic [N-1:0]                n_in      [L];
        logic [N-1:0]                q_in      [L];
        logic [vau_pkg::DREM_W-1:0]  rem_in    [L];
        logic [N-1:0]                q_next    [L];
        logic [vau_pkg::DREM_W-1:0]  rem_next  [L];

        if (g == 0) begin : g_first
            assign v_in    = vld_p_reg;
            assign side_in = side_p_reg;
            assign mag_in  = mag_p_reg;
            assign neg_in  = neg_p_reg;
            for (genvar l = 0; l < L; l++) begin : g_lane
                assign n_in[l]   = n_p_reg[l];
                assign q_in[l]   = '0;
                assign rem_in[l] = '0;
            end
        end else begin : g_rest
            assign v_in    = vld_reg[g-1];
            assign side_in = side_reg[g-1];
            assign mag_in  = mag_reg[g-1];
            assign neg_in  = neg_reg[g-1];
            for (genvar l = 0; l < L; l++) begin : g_lane
                assign n_in[l]   = n_reg[g-1][l];
                assign q_in[l]   = q_reg[g-1][l];
                assign rem_in[l] = rem_reg[g-1][l];
            end
        end

        always_comb begin
            logic [vau_pkg::DREM_W:0] t;
            logic [vau_pkg::DREM_W:0] m_ext;
            m_ext = {1'b0, mag_in};
            for (int l = 0; l < L; l++) begin
                t = {rem_in[l], n_in[l][N-1-g]};
                if (t >= m_ext) begin
                    rem_next[l] = vau_pkg::DREM_W'(t - m_ext);
                    q_next[l]   = {q_in[l][N-2:0], 1'b1};
                end else begin
                    rem_next[l] = t[vau_pkg::DREM_W-1:0];
                    q_next[l]   = {q_in[l][N-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g] <= 1'b0;
            end else if (en) begin
                vld_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[g] <= side_in;
                mag_reg[g]  <= mag_in;
                neg_reg[g]  <= neg_in;
                for (int l = 0; l < L; l++) begin
                    n_reg[g][l]   <= n_in[l];
                    q_reg[g][l]   <= q_next[l];
                    rem_reg[g][l] <= rem_next[l];
                end
            end
        end
    end

    always_comb begin
        vau_pkg::sat_t                       sr;
        vau_pkg::sat_t                       ms;
        logic signed [vau_pkg::SAT_IN_W-1:0] qv;
        vau_pkg::side_t                      sd;
        sd         = side_reg[N-1];
        r_o_next[0] = sd.r_x;
        r_o_next[1] = sd.r_y;
        r_o_next[2] = sd.r_z;
        sc_o_next  = sd.scalar;
        sat_o_next = sd.sat;
        zl_o_next  = 1'b0;
        ms = vau_pkg::sat32({{(vau_pkg::SAT_IN_W-vau_pkg::MAG_W){1'b0}}, mag_reg[N-1]});
        case (sd.kind)
            vau_pkg::OP_MAG: begin
                sc_o_next  = ms.val;
                sat_o_next = ms.flag;
            end
            vau_pkg::OP_UNIT: begin
                if (mag_reg[N-1] == '0) begin
                    zl_o_next = 1'b1;
                    for (int l = 0; l < L; l++) begin
                        r_o_next[l] = '0;
                    end
                end else begin
                    sat_o_next = 1'b0;
                    for (int l = 0; l < L; l++) begin
                        qv = {{(vau_pkg::SAT_IN_W-N){1'b0}}, q_reg[N-1][l]};
                        if (neg_reg[N-1][l]) begin
                            qv = -qv;
                        end
                        sr          = vau_pkg::sat32(qv);
                        r_o_next[l] = sr.val;
                        sat_o_next  = sat_o_next | sr.flag;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_o_reg <= 1'b0;
        end else if (en) begin
            vld_o_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < L; l++) begin
                r_o_reg[l] <= r_o_next[l];
            end
            sc_o_reg  <= sc_o_next;
            sat_o_reg <= sat_o_next;
            zl_o_reg  <= zl_o_next;
        end
    end

    assign out_valid  = vld_o_reg;
    assign out_r_x    = r_o_reg[0];
    assign out_r_y    = r_o_reg[1];
    assign out_r_z    = r_o_reg[2];
    assign out_scalar = sc_o_reg;
    assign out_sat    = sat_o_reg;
    assign out_zl     = zl_o_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/vector3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit
// Q16.16 three-component vector ALU: negate, subtract, add, dot, cross,
// scale, magnitude and unit vector, with saturation and zero-length flags.
//
// Usage:
//   s_* carries one transaction per cycle (opcode, vectors a and b, factor);
//   m_* returns exactly one result per transaction, in order.
//   Every opcode passes through the same stages (Q16.16 data path):
//   4 multiply/sum/round stages, 32 square-root stages plus rounding,
//   a divider prep stage, one stage per quotient bit (32 + FRAC_BITS) and
//   the output register.
//   Throughput is one transaction per cycle when not stalled by m_ready.
//   The whole pipeline advances together; when the receiver holds m_ready
//   low with m_valid high, every stage holds and s_ready drops, so nothing
//   is lost or repeated.
//   Synchronous active-low reset clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_arithmetic_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [2:0]                        s_kind,
    input  wire logic signed [vau_pkg::DATA_W-1:0] s_a_x,
    input  wire logic signed [vau_pkg::DATA_W-1:0] s_a_y,
    input  wire logic signed [vau_pkg::DATA_W-1:0] s_a_z,
    input  wire logic signed [vau_pkg::DATA_W-1:0] s_b_x,
    input  wire logic signed [vau_pkg::DATA_W-1:0] s_b_y,
    input  wire logic signed [vau_pkg::DATA_W-1:0] s_b_z,
    input  wire logic signed [vau_pkg::DATA_W-1:0] s_scale_factor,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [vau_pkg::DATA_W-1:0]      m_r_x,
    output logic signed [vau_pkg::DATA_W-1:0]      m_r_y,
    output logic signed [vau_pkg::DATA_W-1:0]      m_r_z,
    output logic signed [vau_pkg::DATA_W-1:0]      m_scalar_out,
    output logic                                   m_saturated,
    output logic                                   m_zero_length
);

    logic                         en;
    logic                         f_valid;
    vau_pkg::side_t               f_side;
    logic [vau_pkg::PROD_W-1:0]   f_sumsq;
    logic                         q_valid;
    vau_pkg::side_t               q_side;
    logic [vau_pkg::MAG_W-1:0]    q_mag;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    vau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_kind   (vau_pkg::op_t'(s_kind)),
        .in_a_x    (s_a_x),
        .in_a_y    (s_a_y),
        .in_a_z    (s_a_z),
        .in_b_x    (s_b_x),
        .in_b_y    (s_b_y),
        .in_b_z    (s_b_z),
        .in_f      (s_scale_factor),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_sumsq (f_sumsq)
    );

    vau_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_s      (f_sumsq),
        .out_valid (q_valid),
        .out_side  (q_side),
        .out_mag   (q_mag)
    );

    vau_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (q_valid),
        .in_side    (q_side),
        .in_mag     (q_mag),
        .out_valid  (m_valid),
        .out_r_x    (m_r_x),
        .out_r_y    (m_r_y),
        .out_r_z    (m_r_z),
        .out_scalar (m_scalar_out),
        .out_sat    (m_saturated),
        .out_zl     (m_zero_length)
    );

    a_zl_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_length |->
            m_r_x == 0 && m_r_y == 0 && m_r_z == 0 && !m_saturated && m_scalar_out == 0)
        else $error("zero-length result carries nonzero data");

    a_vec_scalar_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_scalar_out != 0 |-> m_r_x == 0 && m_r_y == 0 && m_r_z == 0)
        else $error("scalar and vector results both nonzero");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
